// File: rtl/core/gna_pkg.sv
`timescale 1ns / 1ps
// gna_pkg: shared constants and codes for the grid neighbor address core
// no dependencies
package gna_pkg;

  localparam int COORD_BITS_DEF = 10;
  localparam int SIZE_W         = 11;
  localparam int CFG_DATA_W     = 32;
  localparam int CFG_ADDR_W     = 5;

  typedef enum logic [2:0] {
    OP_EAST      = 3'd0,
    OP_WEST      = 3'd1,
    OP_NORTH     = 3'd2,
    OP_SOUTH     = 3'd3,
    OP_TOP       = 3'd4,
    OP_BOTTOM    = 3'd5,
    OP_DECOMPOSE = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    KIND_ZERO = 2'd0,
    KIND_NBR  = 2'd1,
    KIND_DEC  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    REG_SIZE_X     = 3'd0,
    REG_SIZE_Y     = 3'd1,
    REG_SIZE_Z     = 3'd2,
    REG_PERIODIC_X = 3'd3,
    REG_PERIODIC_Y = 3'd4,
    REG_PERIODIC_Z = 3'd5
  } reg_t;

endpackage

// File: rtl/core/gna_front.sv
`timescale 1ns / 1ps
// gna_front: accepts requests, checks them against the grid and steps the coordinate
// depends on gna_pkg
module gna_front #(
  parameter int COORD_BITS = gna_pkg::COORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                operation,
  input  logic [COORD_BITS-1:0]     coord_x,
  input  logic [COORD_BITS-1:0]     coord_y,
  input  logic [COORD_BITS-1:0]     coord_z,
  input  logic [3*COORD_BITS-1:0]   linear_index,
  input  logic [COORD_BITS:0]       nx,
  input  logic [COORD_BITS:0]       ny,
  input  logic [COORD_BITS:0]       nz,
  input  logic                      per_x,
  input  logic                      per_y,
  input  logic                      per_z,
  output logic                      q_push,
  output logic [2+6*COORD_BITS-1:0] q_data,
  input  logic                      q_full
);
  import gna_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int LIN = 3 * COORD_BITS;
  localparam int EW  = 2 + 6 * COORD_BITS;

  logic          f_valid;
  logic [EW-1:0] f_data;
  logic          load;
  logic          in_grid;
  kind_t         kind;
  logic [C-1:0]  mx, my, mz;
  logic [C:0]    up_x, up_y, up_z;
  logic [LIN-1:0] lin_f;

  assign in_stall = f_valid && q_full;
  assign load     = in_valid && !in_stall;
  assign q_push   = f_valid && !q_full;
  assign q_data   = f_data;

  assign in_grid = ({1'b0, coord_x} < nx) && ({1'b0, coord_y} < ny) && ({1'b0, coord_z} < nz);
  assign up_x    = {1'b0, coord_x} + 1'b1;
  assign up_y    = {1'b0, coord_y} + 1'b1;
  assign up_z    = {1'b0, coord_z} + 1'b1;

  always_comb begin
    mx    = coord_x;
    my    = coord_y;
    mz    = coord_z;
    lin_f = '0;
    kind  = in_grid ? KIND_NBR : KIND_ZERO;
    unique case (op_t'(operation))
      OP_EAST: begin
        if (up_x < nx) mx = up_x[C-1:0];
        else if (per_x) mx = '0;
      end
      OP_WEST: begin
        if (coord_x != '0) mx = coord_x - 1'b1;
        else if (per_x) mx = C'(nx - 1'b1);
      end
      OP_NORTH: begin
        if (up_y < ny) my = up_y[C-1:0];
        else if (per_y) my = '0;
      end
      OP_SOUTH: begin
        if (coord_y != '0) my = coord_y - 1'b1;
        else if (per_y) my = C'(ny - 1'b1);
      end
      OP_TOP: begin
        if (up_z < nz) mz = up_z[C-1:0];
        else if (per_z) mz = '0;
      end
      OP_BOTTOM: begin
        if (coord_z != '0) mz = coord_z - 1'b1;
        else if (per_z) mz = C'(nz - 1'b1);
      end
      OP_DECOMPOSE: begin
        kind  = KIND_DEC;
        lin_f = linear_index;
      end
      default: kind = KIND_ZERO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (load) begin
      f_valid <= 1'b1;
    end else if (q_push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      f_data <= {kind, mx, my, mz, lin_f};
    end
  end

endmodule

// File: rtl/core/gna_queue.sv
`timescale 1ns / 1ps
// gna_queue: two-entry request queue between front and back
// depends on gna_pkg
module gna_queue #(
  parameter int COORD_BITS = gna_pkg::COORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic [2+6*COORD_BITS-1:0] push_data,
  output logic                      full,
  input  logic                      pop,
  output logic                      head_valid,
  output logic [2+6*COORD_BITS-1:0] head_data
);
  import gna_pkg::*;

  localparam int EW = 2 + 6 * COORD_BITS;

  logic [EW-1:0] mem [2];
  logic          wptr, rptr;
  logic [1:0]    count;

  assign full       = count == 2'd2;
  assign head_valid = count != 2'd0;
  assign head_data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop) rptr <= !rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

endmodule

// File: rtl/core/gna_back.sv
`timescale 1ns / 1ps
// gna_back: index multiply pipeline and bit-serial divider for decompose
// depends on gna_pkg
module gna_back #(
  parameter int COORD_BITS = gna_pkg::COORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      head_valid,
  input  logic [2+6*COORD_BITS-1:0] head_data,
  output logic                      pop,
  input  logic [COORD_BITS:0]       nx,
  input  logic [COORD_BITS:0]       ny,
  input  logic [COORD_BITS:0]       nz,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [3*COORD_BITS-1:0]   result_index,
  output logic [COORD_BITS-1:0]     out_x,
  output logic [COORD_BITS-1:0]     out_y,
  output logic [COORD_BITS-1:0]     out_z,
  output logic                      ok
);
  import gna_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int LIN = 3 * COORD_BITS;
  localparam int EW  = 2 + 6 * COORD_BITS;
  localparam int CW  = $clog2(LIN);

  typedef enum logic [3:0] {
    D_IDLE = 4'b0001,
    D_PH1  = 4'b0010,
    D_PH2  = 4'b0100,
    D_DONE = 4'b1000
  } dstate_t;

  kind_t          h_kind;
  logic [C-1:0]   h_x, h_y, h_z;
  logic [LIN-1:0] h_lin;

  dstate_t        dstate, dstate_next;
  logic [CW-1:0]  cnt;
  logic [C+1:0]   rem;
  logic [LIN-1:0] quo;
  logic [C-1:0]   dx, dy;
  logic [C:0]     dsr;
  logic [C+1:0]   trial;
  logic           ge;

  logic           move, nbr_take, div_load, div_take;

  logic           s1_valid;
  kind_t          s1_kind;
  logic [C-1:0]   s1_x, s1_ox, s1_oy, s1_oz;
  logic [2*C-1:0] s1_t;
  logic           s1_ok;
  logic [2*C:0]   prod1;
  logic [3*C:0]   prod2;

  assign h_kind = kind_t'(head_data[EW-1 -: 2]);
  assign {h_x, h_y, h_z, h_lin} = head_data[EW-3:0];

  assign move     = !out_valid || !out_stall;
  assign div_load = head_valid && h_kind == KIND_DEC && dstate == D_IDLE;
  assign nbr_take = move && head_valid && h_kind != KIND_DEC && dstate == D_IDLE;
  assign div_take = move && dstate == D_DONE;
  assign pop      = div_load || nbr_take;

  assign dsr   = (dstate == D_PH1) ? nx : ny;
  assign trial = {rem[C:0], quo[LIN-1]};
  assign ge    = trial >= {1'b0, dsr};

  always_comb begin
    dstate_next = dstate;
    unique case (dstate)
      D_IDLE: if (div_load) dstate_next = D_PH1;
      D_PH1:  if (cnt == '0) dstate_next = D_PH2;
      D_PH2:  if (cnt == '0) dstate_next = D_DONE;
      D_DONE: if (div_take) dstate_next = D_IDLE;
      default: dstate_next = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dstate <= D_IDLE;
    end else begin
      dstate <= dstate_next;
    end
  end

  // shift-subtract, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (div_load) begin
      quo <= h_lin;
      rem <= '0;
      cnt <= CW'(LIN - 1);
    end else if (dstate == D_PH1 || dstate == D_PH2) begin
      quo <= {quo[LIN-2:0], ge};
      if (cnt == '0) begin
        rem <= '0;
        cnt <= CW'(LIN - 1);
        if (dstate == D_PH1) dx <= C'(ge ? trial - {1'b0, dsr} : trial);
        else dy <= C'(ge ? trial - {1'b0, dsr} : trial);
      end else begin
        rem <= ge ? trial - {1'b0, dsr} : trial;
        cnt <= cnt - 1'b1;
      end
    end
  end

  assign prod1 = ny * h_z;
  assign prod2 = nx * s1_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (move) begin
      s1_valid  <= nbr_take || div_take;
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      if (div_take) begin
        s1_kind <= KIND_DEC;
        s1_x    <= '0;
        s1_t    <= '0;
        s1_ok   <= quo < LIN'(nz);
        s1_ox   <= dx;
        s1_oy   <= dy;
        s1_oz   <= quo[C-1:0];
      end else begin
        s1_kind <= h_kind;
        s1_x    <= h_x;
        s1_t    <= (2*C)'(prod1 + (2*C+1)'(h_y));
        s1_ok   <= h_kind == KIND_NBR;
        s1_ox   <= '0;
        s1_oy   <= '0;
        s1_oz   <= '0;
      end
      result_index <= (s1_kind == KIND_NBR) ? LIN'(prod2 + (3*C+1)'(s1_x)) : '0;
      out_x        <= s1_ok ? s1_ox : '0;
      out_y        <= s1_ok ? s1_oy : '0;
      out_z        <= s1_ok ? s1_oz : '0;
      ok           <= s1_ok;
    end
  end

endmodule

// File: rtl/core/grid_neighbor_address_core.sv
`timescale 1ns / 1ps
// Address unit for a 3-D structured grid. Neighbor requests (east, west, north, south,
// top, bottom) go at one per cycle unless the result side or the divider holds them
// back, via one front register, the queue, and two multiply stages forming
// x + nx*(y + ny*z). A decompose request runs through a shared shift-subtract divider,
// one quotient bit a cycle, twice over 3*COORD_BITS bits, and holds the back part;
// requests behind it wait in the queue. Sizes and wrap modes are set over the APB port
// and must only change while no request is in flight. No clearing pass after reset.
// depends on gna_pkg, gna_front, gna_queue, gna_back
module grid_neighbor_address_core #(
  parameter int COORD_BITS = gna_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gna_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [gna_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [gna_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        operation,
  input  logic [COORD_BITS-1:0]             coord_x,
  input  logic [COORD_BITS-1:0]             coord_y,
  input  logic [COORD_BITS-1:0]             coord_z,
  input  logic [3*COORD_BITS-1:0]           linear_index,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [3*COORD_BITS-1:0]           result_index,
  output logic [COORD_BITS-1:0]             out_x,
  output logic [COORD_BITS-1:0]             out_y,
  output logic [COORD_BITS-1:0]             out_z,
  output logic                              ok
);
  import gna_pkg::*;

  localparam int EW    = 2 + 6 * COORD_BITS;
  localparam int SW    = COORD_BITS + 1;
  localparam int CMP_W = (SW > SIZE_W) ? SW : SIZE_W;
  localparam logic [CMP_W-1:0] MAX_CELLS = CMP_W'(1) << COORD_BITS;

  logic [SIZE_W-1:0] size_x, size_y, size_z;
  logic              periodic_x, periodic_y, periodic_z;
  logic [SW-1:0]     nx, ny, nz;
  logic              wr;
  logic              q_push, q_full, q_pop, q_valid;
  logic [EW-1:0]     q_in, q_head;

  function automatic logic [SW-1:0] eff_size(input logic [SIZE_W-1:0] v);
    logic [CMP_W-1:0] w;
    w = CMP_W'(v);
    if (v == '0) return SW'(1);
    else if (w > MAX_CELLS) return SW'(MAX_CELLS);
    else return SW'(w);
  endfunction

  assign nx     = eff_size(size_x);
  assign ny     = eff_size(size_y);
  assign nz     = eff_size(size_z);
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x     <= SIZE_W'(1);
      size_y     <= SIZE_W'(1);
      size_z     <= SIZE_W'(1);
      periodic_x <= 1'b0;
      periodic_y <= 1'b0;
      periodic_z <= 1'b0;
    end else if (wr) begin
      unique case (reg_t'(paddr[4:2]))
        REG_SIZE_X:     size_x     <= pwdata[SIZE_W-1:0];
        REG_SIZE_Y:     size_y     <= pwdata[SIZE_W-1:0];
        REG_SIZE_Z:     size_z     <= pwdata[SIZE_W-1:0];
        REG_PERIODIC_X: periodic_x <= pwdata[0];
        REG_PERIODIC_Y: periodic_y <= pwdata[0];
        REG_PERIODIC_Z: periodic_z <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_t'(paddr[4:2]))
      REG_SIZE_X:     prdata = CFG_DATA_W'(size_x);
      REG_SIZE_Y:     prdata = CFG_DATA_W'(size_y);
      REG_SIZE_Z:     prdata = CFG_DATA_W'(size_z);
      REG_PERIODIC_X: prdata = CFG_DATA_W'(periodic_x);
      REG_PERIODIC_Y: prdata = CFG_DATA_W'(periodic_y);
      REG_PERIODIC_Z: prdata = CFG_DATA_W'(periodic_z);
      default:        prdata = '0;
    endcase
  end

  gna_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .linear_index(linear_index),
    .nx(nx), .ny(ny), .nz(nz),
    .per_x(periodic_x), .per_y(periodic_y), .per_z(periodic_z),
    .q_push(q_push), .q_data(q_in), .q_full(q_full)
  );

  gna_queue #(.COORD_BITS(COORD_BITS)) u_queue (
    .clk(clk), .rst(rst),
    .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .head_valid(q_valid), .head_data(q_head)
  );

  gna_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk(clk), .rst(rst),
    .head_valid(q_valid), .head_data(q_head), .pop(q_pop),
    .nx(nx), .ny(ny), .nz(nz),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_index(result_index), .out_x(out_x), .out_y(out_y), .out_z(out_z), .ok(ok)
  );

endmodule

// File: rtl/core/gna_checker.sv
`timescale 1ns / 1ps
// gna_checker: port-level checks for the grid neighbor address core, bound to the top
// depends on gna_pkg, grid_neighbor_address_core
module gna_checker #(
  parameter int COORD_BITS = gna_pkg::COORD_BITS_DEF
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [3*COORD_BITS-1:0] result_index,
  input logic [COORD_BITS-1:0]   out_x,
  input logic [COORD_BITS-1:0]   out_y,
  input logic [COORD_BITS-1:0]   out_z,
  input logic                    ok
);
  import gna_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_index) && $stable(ok))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> result_index == '0 && out_x == '0 && out_y == '0 && out_z == '0)
    else $error("failed request carries data");

  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_index != '0 |-> ok && out_x == '0 && out_y == '0 && out_z == '0)
    else $error("neighbor result mixed with coordinates");

endmodule

bind grid_neighbor_address_core gna_checker #(.COORD_BITS(COORD_BITS)) u_gna_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .result_index(result_index), .out_x(out_x), .out_y(out_y), .out_z(out_z), .ok(ok)
);

// File: sim/testbench.sv
`timescale 1ns / 1ps
// testbench: random and directed check of grid_neighbor_address_core, with its own
// address predictor, an apb config writer and randomly idling request and result sides
// depends on gna_pkg and grid_neighbor_address_core
module testbench;
  import gna_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int LB = 3 * CB;
  localparam logic [2:0] OP_UNUSED = 3'd7;

  typedef struct {
    logic [2:0]    op;
    logic [CB-1:0] x, y, z;
    logic [LB-1:0] lin;
  } request_t;

  typedef struct {
    logic [LB-1:0] index;
    logic [CB-1:0] x, y, z;
    logic          ok;
  } address_t;

  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 0, in_stall;
  logic [2:0] operation = '0;
  logic [CB-1:0] coord_x = '0, coord_y = '0, coord_z = '0;
  logic [LB-1:0] linear_index = '0;
  logic out_valid, out_stall = 0;
  logic [LB-1:0] result_index;
  logic [CB-1:0] out_x, out_y, out_z;
  logic ok;

  grid_neighbor_address_core #(.COORD_BITS(CB)) DUT (.*);

  logic [SIZE_W-1:0] size_reg [3];
  logic              wrap_reg [3];
  request_t pending_requests [$];
  address_t expected_addresses [$];
  int  fail_count = 0;
  bit  quiet = 0;
  int  results_seen = 0;
  int  hold_left = 0;
  bit  hold_done = 0;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic longint eff_size(int axis);
    longint v;
    v = size_reg[axis];
    if (v == 0) return 1;
    if (v > (1 << CB)) return 1 << CB;
    return v;
  endfunction

  function automatic longint step_axis(longint c, longint n, logic wrap, bit down);
    if (!down) return (c + 1 < n) ? c + 1 : (wrap ? 0 : c);
    if (c != 0) return c - 1;
    return wrap ? n - 1 : 0;
  endfunction

  function automatic address_t predict_address(request_t r);
    address_t a;
    longint nx, ny, nz, x, y, z, rest;
    nx = eff_size(0);
    ny = eff_size(1);
    nz = eff_size(2);
    x = r.x;
    y = r.y;
    z = r.z;
    a = '{index: '0, x: '0, y: '0, z: '0, ok: 0};
    if (r.op == OP_DECOMPOSE) begin
      if (longint'(r.lin) < nx * ny * nz) begin
        a.x = CB'(r.lin % nx);
        rest = r.lin / nx;
        a.y = CB'(rest % ny);
        a.z = CB'(rest / ny);
        a.ok = 1;
      end
      return a;
    end
    if (r.op == OP_UNUSED || x >= nx || y >= ny || z >= nz) return a;
    case (r.op)
      OP_EAST:   x = step_axis(x, nx, wrap_reg[0], 0);
      OP_WEST:   x = step_axis(x, nx, wrap_reg[0], 1);
      OP_NORTH:  y = step_axis(y, ny, wrap_reg[1], 0);
      OP_SOUTH:  y = step_axis(y, ny, wrap_reg[1], 1);
      OP_TOP:    z = step_axis(z, nz, wrap_reg[2], 0);
      default:   z = step_axis(z, nz, wrap_reg[2], 1);
    endcase
    a.index = LB'(x + nx * (y + ny * z));
    a.ok = 1;
    return a;
  endfunction

  task automatic add_request(request_t r);
    pending_requests = {pending_requests, r};
  endtask

  // request driver
  always @(posedge clk) begin
    request_t r;
    bit fire;
    if (rst) begin
      in_valid <= 0;
    end else begin
      fire = in_valid && !in_stall;
      if (fire) begin
        r = '{op: operation, x: coord_x, y: coord_y, z: coord_z, lin: linear_index};
        expected_addresses = {expected_addresses, predict_address(r)};
      end
      if (!in_valid || fire) begin
        if (pending_requests.size() > 0 && (quiet || $urandom_range(0, 99) >= 11)) begin
          r = pending_requests.pop_front();
          in_valid <= 1;
          operation <= r.op;
          coord_x <= r.x;
          coord_y <= r.y;
          coord_z <= r.z;
          linear_index <= r.lin;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    address_t e;
    if (rst) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_addresses.size() == 0) begin
          $error("unexpected result index %0d", result_index);
          fail_count++;
        end else begin
          e = expected_addresses.pop_front();
          if (result_index !== e.index) begin
            $error("result_index expected %0d got %0d", e.index, result_index);
            fail_count++;
          end
          if (out_x !== e.x) begin
            $error("out_x expected %0d got %0d", e.x, out_x);
            fail_count++;
          end
          if (out_y !== e.y) begin
            $error("out_y expected %0d got %0d", e.y, out_y);
            fail_count++;
          end
          if (out_z !== e.z) begin
            $error("out_z expected %0d got %0d", e.z, out_z);
            fail_count++;
          end
          if (ok !== e.ok) begin
            $error("ok expected %0d got %0d", e.ok, ok);
            fail_count++;
          end
        end
      end
      if (!hold_done && results_seen >= 400) begin
        hold_done = 1;
        hold_left = 200;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1;
      end else begin
        out_stall <= !quiet && $urandom_range(0, 99) < 11;
      end
    end
  end

  task automatic write_reg(reg_t idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= CFG_ADDR_W'(4 * idx);
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    if (idx <= REG_SIZE_Z) size_reg[idx] = value[SIZE_W-1:0];
    else wrap_reg[idx - REG_PERIODIC_X] = value[0];
  endtask

  task automatic set_grid(int sx, int sy, int sz, bit wx, bit wy, bit wz);
    write_reg(REG_SIZE_X, CFG_DATA_W'(sx));
    write_reg(REG_SIZE_Y, CFG_DATA_W'(sy));
    write_reg(REG_SIZE_Z, CFG_DATA_W'(sz));
    write_reg(REG_PERIODIC_X, CFG_DATA_W'(wx));
    write_reg(REG_PERIODIC_Y, CFG_DATA_W'(wy));
    write_reg(REG_PERIODIC_Z, CFG_DATA_W'(wz));
  endtask

  function automatic request_t make_request(logic [2:0] op, int x, int y, int z, longint lin);
    request_t r;
    r = '{op: op, x: CB'(x), y: CB'(y), z: CB'(z), lin: LB'(lin)};
    return r;
  endfunction

  function automatic logic [CB-1:0] pick_coord(longint n);
    int k;
    k = $urandom_range(0, 9);
    if (k < 2) return '0;
    if (k < 4) return CB'(n - 1);
    if (k == 4) return CB'($urandom);
    if (k == 5) return CB'(n);
    return CB'($urandom_range(0, int'(n - 1)));
  endfunction

  function automatic request_t random_request();
    request_t r;
    longint total;
    int k;
    total = eff_size(0) * eff_size(1) * eff_size(2);
    r.op = ($urandom_range(0, 19) == 0) ? OP_UNUSED : 3'($urandom_range(0, 6));
    r.x = pick_coord(eff_size(0));
    r.y = pick_coord(eff_size(1));
    r.z = pick_coord(eff_size(2));
    k = $urandom_range(0, 9);
    if (k == 0) r.lin = LB'(total);
    else if (k == 1) r.lin = LB'(total - 1);
    else if (k == 2) r.lin = LB'({$urandom, $urandom});
    else r.lin = LB'({$urandom, $urandom} % total);
    return r;
  endfunction

  task automatic drain();
    while (pending_requests.size() > 0 || in_valid || expected_addresses.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  initial begin
    int grids [8][6];
    grids = '{'{5, 4, 3, 1, 1, 1}, '{1, 1, 1, 0, 0, 0}, '{1024, 1024, 1024, 1, 0, 1},
              '{0, 2047, 7, 0, 1, 0}, '{17, 33, 2, 1, 1, 1}, '{1024, 1, 1024, 0, 0, 0},
              '{3, 1024, 9, 1, 1, 0}, '{100, 50, 200, 0, 1, 1}};
    size_reg = '{default: 1};
    wrap_reg = '{default: 0};
    repeat (10) @(posedge clk);
    rst <= 0;
    for (int p = 0; p < 8; p++) begin
      set_grid(grids[p][0], grids[p][1], grids[p][2], grids[p][3], grids[p][4], grids[p][5]);
      quiet = (p == 4);
      if (p == 0) begin
        // corners with wrap on, outside cells, index bounds, unused operation
        for (int o = 0; o < 6; o++) begin
          add_request(make_request(3'(o), 0, 0, 0, 0));
          add_request(make_request(3'(o), 4, 3, 2, 0));
        end
        add_request(make_request(OP_EAST, 5, 0, 0, 0));
        add_request(make_request(OP_NORTH, 0, 4, 0, 0));
        add_request(make_request(OP_TOP, 1023, 1023, 1023, 0));
        add_request(make_request(OP_DECOMPOSE, 0, 0, 0, 0));
        add_request(make_request(OP_DECOMPOSE, 0, 0, 0, 59));
        add_request(make_request(OP_DECOMPOSE, 0, 0, 0, 60));
        add_request(make_request(OP_DECOMPOSE, 1023, 1023, 1023,
                                 (longint'(1) << LB) - 1));
        add_request(make_request(OP_UNUSED, 1, 1, 1, 7));
        add_request(make_request(OP_UNUSED, 1023, 1023, 1023,
                                 (longint'(1) << LB) - 1));
      end
      for (int i = 0; i < 190; i++) add_request(random_request());
      drain();
    end
    if (fail_count == 0 && expected_addresses.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/gna_pkg.sv
rtl/core/gna_front.sv
rtl/core/gna_queue.sv
rtl/core/gna_back.sv
rtl/core/grid_neighbor_address_core.sv
rtl/core/gna_checker.sv
sim/testbench.sv
